// ===== design/sc2a_pkg.sv =====
// Package: scancode constants and set-1 ASCII lookup tables.
`timescale 1ns / 1ps
`default_nettype none
package sc2a_pkg;

  localparam int unsigned CODE_W  = 8;
  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned MAP_SIZE = 58;
  localparam int unsigned IDX_W   = $clog2(MAP_SIZE);

  localparam logic [CODE_W-1:0] SC_LSHIFT_MAKE  = 8'h2A;
  localparam logic [CODE_W-1:0] SC_RSHIFT_MAKE  = 8'h36;
  localparam logic [CODE_W-1:0] SC_LSHIFT_BREAK = 8'hAA;
  localparam logic [CODE_W-1:0] SC_RSHIFT_BREAK = 8'hB6;
  localparam logic [CODE_W-1:0] SC_CAPS_MAKE    = 8'h3A;
  localparam logic [CODE_W-1:0] SC_BACKSPACE    = 8'h0E;
  localparam int unsigned       SC_BREAK_BIT    = 7;

  localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 7'h08;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A   = 7'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z   = 7'h7A;
  localparam logic [CHAR_W-1:0] CASE_OFFSET    = 7'd32;

  typedef logic [CHAR_W-1:0] char_t;
  typedef char_t map_t [MAP_SIZE];

  localparam map_t PLAIN_MAP = '{
    7'h00, 7'h1B, 7'("1"), 7'("2"), 7'("3"), 7'("4"), 7'("5"), 7'("6"),
    7'("7"), 7'("8"), 7'("9"), 7'("0"), 7'("-"), 7'("="), 7'h08,
    7'h09, 7'("q"), 7'("w"), 7'("e"), 7'("r"), 7'("t"), 7'("y"),
    7'("u"), 7'("i"), 7'("o"), 7'("p"), 7'("["), 7'("]"), 7'h0A,
    7'h00, 7'("a"), 7'("s"), 7'("d"), 7'("f"), 7'("g"), 7'("h"),
    7'("j"), 7'("k"), 7'("l"), 7'(";"), 7'h27, 7'h60,
    7'h00, 7'h5C, 7'("z"), 7'("x"), 7'("c"), 7'("v"),
    7'("b"), 7'("n"), 7'("m"), 7'(","), 7'("."), 7'("/"),
    7'h00, 7'("*"), 7'h00, 7'h20
  };

  localparam map_t SHIFTED_MAP = '{
    7'h00, 7'h1B, 7'("!"), 7'("@"), 7'("#"), 7'("$"), 7'("%"), 7'("^"),
    7'("&"), 7'("*"), 7'("("), 7'(")"), 7'("_"), 7'("+"), 7'h08,
    7'h09, 7'("Q"), 7'("W"), 7'("E"), 7'("R"), 7'("T"), 7'("Y"),
    7'("U"), 7'("I"), 7'("O"), 7'("P"), 7'("{"), 7'("}"), 7'h0A,
    7'h00, 7'("A"), 7'("S"), 7'("D"), 7'("F"), 7'("G"), 7'("H"),
    7'("J"), 7'("K"), 7'("L"), 7'(":"), 7'h22, 7'h7E,
    7'h00, 7'h7C, 7'("Z"), 7'("X"), 7'("C"), 7'("V"),
    7'("B"), 7'("N"), 7'("M"), 7'("<"), 7'(">"), 7'("?"),
    7'h00, 7'("*"), 7'h00, 7'h20
  };

endpackage
`default_nettype wire

// ===== design/sc2a_if.sv =====
// Interfaces: scancode input stream and ASCII character output stream.
`timescale 1ns / 1ps
`default_nettype none
interface sc2a_code_if
  import sc2a_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] scancode;

  modport source (output valid, output scancode, input ready);
  modport sink   (input valid, input scancode, output ready);
endinterface

interface sc2a_char_if
  import sc2a_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] ascii_char;

  modport source (output valid, output ascii_char, input ready);
  modport sink   (input valid, input ascii_char, output ready);
endinterface
`default_nettype wire

// ===== design/scancode_set1_to_ascii_unit.sv =====
// Top level: set-1 scancode to ASCII translator with shift and caps lock tracking.
// A scancode is held in the input register while it is translated; its character goes into the result register.
// Throughput: one scancode per cycle unless the result side stalls; the table lookup and flag update fit in one stage.
// A code that yields no character (modifiers, breaks, unmapped keys) just leaves a bubble.
// Backpressure from the result side stalls the input register and then the input.
// Reset (rst, synchronous): clears shift and caps flags and both valid bits.
`timescale 1ns / 1ps
`default_nettype none
module scancode_set1_to_ascii_unit
  import sc2a_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  sc2a_code_if.sink   codes,
  sc2a_char_if.source chars
);

  // Input register
  logic              code_valid;
  logic [CODE_W-1:0] code_q;

  // Keyboard modifier state
  logic shift_held;
  logic caps_active;
  logic shift_held_next;
  logic caps_active_next;

  // Result register
  logic        out_valid;
  char_t       out_char;

  // Decode of the registered code
  logic        emit;
  char_t       ch;
  char_t       ch_lookup;
  logic [IDX_W-1:0] idx;
  logic        in_map;
  logic        advance;

  // The registered code moves on whenever the result register is free or draining.
  assign advance      = code_valid && (!out_valid || chars.ready);
  assign codes.ready  = !code_valid || advance;

  assign chars.valid      = out_valid;
  assign chars.ascii_char = out_char;

  assign idx    = code_q[IDX_W-1:0];
  assign in_map = (code_q < CODE_W'(MAP_SIZE));

  always_comb begin
    ch_lookup = shift_held ? SHIFTED_MAP[idx] : PLAIN_MAP[idx];
  end

  // Translation: flags first, then breaks, caps lock, backspace, table.
  always_comb begin
    shift_held_next  = shift_held;
    caps_active_next = caps_active;
    emit             = 1'b0;
    ch               = ch_lookup;
    if (code_q == SC_LSHIFT_MAKE || code_q == SC_RSHIFT_MAKE) begin
      shift_held_next = 1'b1;
    end else if (code_q == SC_LSHIFT_BREAK || code_q == SC_RSHIFT_BREAK) begin
      shift_held_next = 1'b0;
    end else if (code_q[SC_BREAK_BIT]) begin
      emit = 1'b0;                              // other key releases ignored
    end else if (code_q == SC_CAPS_MAKE) begin
      caps_active_next = !caps_active;
    end else if (code_q == SC_BACKSPACE) begin
      emit = 1'b1;
      ch   = CHAR_BACKSPACE;
    end else if (in_map && ch_lookup != '0) begin
      emit = 1'b1;
      // caps lock only uppercases letters, and only with shift up
      if (!shift_held && caps_active &&
          ch_lookup >= CHAR_LOWER_A && ch_lookup <= CHAR_LOWER_Z) begin
        ch = ch_lookup - CASE_OFFSET;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_valid  <= 1'b0;
      shift_held  <= 1'b0;
      caps_active <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (codes.ready) begin
        code_valid <= codes.valid;
      end
      if (advance) begin
        shift_held  <= shift_held_next;
        caps_active <= caps_active_next;
        out_valid   <= emit;
      end else if (chars.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (codes.valid && codes.ready) begin
      code_q <= codes.scancode;
    end
    if (advance && emit) begin
      out_char <= ch;
    end
  end

  // Checks
  a_no_null_char: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_char != '0)
    else $error("null character presented");

  a_caps_toggle: assert property (@(posedge clk) disable iff (rst)
    (advance && code_q == SC_CAPS_MAKE) |=> caps_active != $past(caps_active))
    else $error("caps lock did not toggle");

  a_shift_make: assert property (@(posedge clk) disable iff (rst)
    (advance && (code_q == SC_LSHIFT_MAKE || code_q == SC_RSHIFT_MAKE)) |=> shift_held)
    else $error("shift make not latched");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !code_valid |-> codes.ready)
    else $error("input stalled with empty input register");

endmodule
`default_nettype wire

// ===== tb/sv/tb_scancode_set1_to_ascii_unit.sv =====
// Testbench: checks the set-1 scancode to ASCII unit's characters against an in-bench translator.
`timescale 1ns / 1ps
`default_nettype none
module tb_scancode_set1_to_ascii_unit;
  import sc2a_pkg::*;

  // Key scancodes used by the directed part (make codes).
  localparam logic [CODE_W-1:0] KEY_NONE0  = 8'h00;  // table hole at index zero
  localparam logic [CODE_W-1:0] KEY_ESC    = 8'h01;
  localparam logic [CODE_W-1:0] KEY_1      = 8'h02;
  localparam logic [CODE_W-1:0] KEY_Q      = 8'h10;
  localparam logic [CODE_W-1:0] KEY_LBRACK = 8'h1A;
  localparam logic [CODE_W-1:0] KEY_CTRL   = 8'h1D;  // unmapped, zero in both tables
  localparam logic [CODE_W-1:0] KEY_BSLASH = 8'h2B;
  localparam logic [CODE_W-1:0] KEY_STAR   = 8'h37;
  localparam logic [CODE_W-1:0] KEY_SPACE  = 8'h39;
  localparam logic [CODE_W-1:0] KEY_F1     = 8'h3B;  // past the tables
  localparam logic [CODE_W-1:0] KEY_Q_BRK  = 8'h90;  // release of Q, ignored

  localparam int unsigned RANDOM_CODES = 1500;
  localparam int unsigned QUIET_TAIL   = 200;  // last codes go out with no idling
  localparam int unsigned HOLD_AT      = 400;  // transfer count that starts the long hold-off
  localparam int unsigned HOLD_CYCLES  = 100;
  localparam int unsigned DRAIN_CYCLES = 10;

  // Expected characters per code, keyed by scancode.
  localparam char_t plain_keys [MAP_SIZE] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08,
    7'h09, 7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79,
    7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A,
    7'h00, 7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68,
    7'h6A, 7'h6B, 7'h6C, 7'h3B, 7'h27, 7'h60,
    7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F,
    7'h00, 7'h2A, 7'h00, 7'h20
  };

  localparam char_t shifted_keys [MAP_SIZE] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08,
    7'h09, 7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59,
    7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A,
    7'h00, 7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48,
    7'h4A, 7'h4B, 7'h4C, 7'h3A, 7'h22, 7'h7E,
    7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F,
    7'h00, 7'h2A, 7'h00, 7'h20
  };

  logic clk;
  logic rst;

  sc2a_code_if code_bus ();
  sc2a_char_if char_bus ();

  scancode_set1_to_ascii_unit dut (
    .clk   (clk),
    .rst   (rst),
    .codes (code_bus.sink),
    .chars (char_bus.source)
  );

  // Scancodes waiting to be driven, and characters the unit still owes us.
  logic [CODE_W-1:0] pending_codes [$];
  char_t             expected_chars [$];

  // Keyboard state as the bench tracks it.
  bit shift_down;
  bit caps_on;

  bit          code_taken;      // a scancode transfer happened at the last rising edge
  int unsigned codes_accepted;
  int unsigned mismatch_count;

  // Sender / receiver idling state.
  int unsigned send_gap;
  int unsigned recv_stall;
  int unsigned hold_left;
  bit          hold_done;

  // Translate one accepted scancode and update the shift / caps flags.
  // Returns 1 when the code yields a character.
  function automatic bit translate_code(input logic [CODE_W-1:0] code, output char_t ch);
    ch = '0;
    // Shift make / break only move the shift flag.
    if (code == SC_LSHIFT_MAKE || code == SC_RSHIFT_MAKE) begin
      shift_down = 1'b1;
      return 1'b0;
    end
    if (code == SC_LSHIFT_BREAK || code == SC_RSHIFT_BREAK) begin
      shift_down = 1'b0;
      return 1'b0;
    end
    // Any other release is dropped.
    if (code[SC_BREAK_BIT])
      return 1'b0;
    if (code == SC_CAPS_MAKE) begin
      caps_on = !caps_on;
      return 1'b0;
    end
    // Backspace is the same with or without shift.
    if (code == SC_BACKSPACE) begin
      ch = CHAR_BACKSPACE;
      return 1'b1;
    end
    // F-keys and up: past the tables, nothing comes out.
    if (code >= MAP_SIZE)
      return 1'b0;
    ch = shift_down ? shifted_keys[code] : plain_keys[code];
    if (ch == '0)
      return 1'b0;
    // Caps lock only raises letters, and only while shift is up.
    if (!shift_down && caps_on && ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z)
      ch = ch - CASE_OFFSET;
    return 1'b1;
  endfunction

  // Random scancode, weighted toward typing: mostly make codes inside the tables,
  // with shift and caps activity sprinkled in, plus releases and out-of-table noise.
  function automatic logic [CODE_W-1:0] random_code();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 68)
      return CODE_W'($urandom_range(0, MAP_SIZE - 1));
    else if (pick < 76)
      return $urandom_range(0, 1) ? SC_LSHIFT_MAKE : SC_RSHIFT_MAKE;
    else if (pick < 84)
      return $urandom_range(0, 1) ? SC_LSHIFT_BREAK : SC_RSHIFT_BREAK;
    else if (pick < 89)
      return SC_CAPS_MAKE;
    else if (pick < 95)
      return CODE_W'($urandom_range(8'h80, 8'hFF));
    else
      return CODE_W'($urandom_range(MAP_SIZE + 1, 8'h7F));
  endfunction

  // Idling is on except in the tail and in every third block of 150 transfers.
  function automatic bit idling_allowed();
    return pending_codes.size() > QUIET_TAIL && ((codes_accepted / 150) % 3) != 2;
  endfunction

  // Clock, reset, and known values on every input from time zero.
  initial begin
    clk = 1'b0;
    rst = 1'b1;
    code_bus.valid    = 1'b0;
    code_bus.scancode = '0;
    char_bus.ready    = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
  end

  // Sender: changes at the falling edge, one transfer per item, random gaps after transfers.
  always @(negedge clk) begin
    if (rst) begin
      code_bus.valid <= 1'b0;
    end else if (!code_bus.valid || code_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        code_bus.valid <= 1'b0;
      end else if (pending_codes.size() > 0) begin
        code_bus.valid    <= 1'b1;
        code_bus.scancode <= pending_codes.pop_front();
        if (idling_allowed() && $urandom_range(0, 5) == 0)
          send_gap = $urandom_range(1, 5);
      end else begin
        code_bus.valid <= 1'b0;
      end
    end
  end

  // Receiver: random short stalls, plus one long hold-off so the unit backs up
  // into its input while the sender keeps offering.
  always @(negedge clk) begin
    bit take;
    take = 1'b1;
    if (rst) begin
      take = 1'b0;
    end else begin
      if (!hold_done && codes_accepted >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        take = 1'b0;
      end else if (idling_allowed() && $urandom_range(0, 5) == 0) begin
        recv_stall = $urandom_range(0, 4);
        take = 1'b0;
      end
    end
    char_bus.ready <= take;
  end

  // Monitor: samples both channels at the rising edge. Input transfers feed the
  // translator; output transfers are checked against the oldest expected character.
  always @(posedge clk) begin
    char_t want;
    char_t got;
    if (rst) begin
      code_taken <= 1'b0;
    end else begin
      code_taken <= code_bus.valid && code_bus.ready;
      if (code_bus.valid && code_bus.ready) begin
        codes_accepted++;
        if (translate_code(code_bus.scancode, want))
          expected_chars.push_back(want);
      end
      if (char_bus.valid && char_bus.ready) begin
        got = char_bus.ascii_char;
        if (expected_chars.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected character, expected none, actual 0x%02h", $time, got);
        end else begin
          want = expected_chars.pop_front();
          if (got !== want) begin
            mismatch_count++;
            $display("%0t: ascii_char mismatch, expected 0x%02h, actual 0x%02h",
                     $time, want, got);
          end
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    // Directed part: table holes, both tables, caps on letters and digits,
    // shift overriding caps, backspace under shift, releases and out-of-table codes.
    pending_codes = '{
      KEY_NONE0, KEY_ESC, KEY_Q, SC_CAPS_MAKE, KEY_Q, KEY_1,
      SC_LSHIFT_MAKE, KEY_Q, SC_BACKSPACE, KEY_SPACE, KEY_STAR,
      SC_LSHIFT_BREAK, SC_CAPS_MAKE, KEY_Q,
      SC_RSHIFT_MAKE, KEY_LBRACK, KEY_BSLASH, KEY_Q_BRK, SC_RSHIFT_BREAK,
      KEY_CTRL, KEY_F1, 8'h7F, 8'h80, 8'hFF, SC_BACKSPACE
    };
    for (int i = 0; i < RANDOM_CODES; i++)
      pending_codes.push_back(random_code());

    @(negedge clk);
    while (rst || pending_codes.size() > 0 || code_bus.valid)
      @(posedge clk);
    while (expected_chars.size() > 0)
      @(posedge clk);
    // Leave room for a stray character still in the pipe.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_chars.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire
